[sv/smt_pkg.sv]
`default_nettype none
package smt_pkg;
  localparam int unsigned DimW = 11;
  localparam int unsigned CountW = 13;
  localparam int unsigned ValW = 32;
  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned MAX_NNZ = 4096;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_FETCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PHASE_LOAD = 2'd0,
    PHASE_HEADER = 2'd1,
    PHASE_ENTRY = 2'd2,
    PHASE_DONE = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_ADD,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_FETCH_RD,
    ST_FETCH_EMIT,
    ST_MOVE_CUR
  } state_t;

  localparam logic [1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [1:0] REG_NUM_COLS = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [DimW-1:0] out_row;
    logic [DimW-1:0] out_col;
    logic signed [ValW-1:0] out_value;
    logic [CountW-1:0] row_count;
    logic last_in_row;
    logic last_of_all;
    logic load_error;
  } result_t;

  typedef struct packed {
    logic opcode;
    logic [DimW-1:0] row_index;
    logic [DimW-1:0] col_index;
    logic signed [ValW-1:0] entry_value;
  } item_t;
endpackage
`default_nettype wire

[sv/smt_if.sv]
`default_nettype none
interface smt_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/sparse_matrix_transpose_top.sv]
// Sparse matrix transpose from row order to column order. Opcode 0 loads one nonzero
// entry and gives no result; opcode 1 fetches the next result of the transpose: a header
// with the count of each transposed row, then that row's entries, then "nothing left".
// One memory access per cycle sets the timing. A load reads its column count and writes
// it back incremented. A fetch reads the memories in ST_FETCH_RD and fills the output
// register in ST_FETCH_EMIT, and no new transfer is accepted until that result is taken,
// so a new fetch cannot start before the last result is taken. The first fetch of a
// matrix first runs a counting sort: ST_SCAN and ST_SCAN_ADD for each of the MAX_DIM
// columns, then ST_MOVE_RD, ST_MOVE_CUR and ST_MOVE_WR for each loaded entry. The first
// load after fetching starts a new matrix and first clears the column counts, one per
// cycle; the same clearing pass runs after reset, while the input is not ready.
`default_nettype none
module sparse_matrix_transpose_top
  import smt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  smt_if.sink in_ch,
  smt_if.source out_ch,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [2:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned NW = $clog2(MAX_NNZ);

  logic [DimW-1:0] num_rows, num_cols;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DimW'(1);
      num_cols <= DimW'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_NUM_COLS[0]) num_cols <= pwdata[DimW-1:0];
      else num_rows <= pwdata[DimW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NUM_COLS[0]) prdata[DimW-1:0] = num_cols;
    else prdata[DimW-1:0] = num_rows;
  end

  function automatic logic [DimW:0] eff(input logic [DimW-1:0] v);
    if (v == '0) return (DimW+1)'(1);
    if ({1'b0, v} > (DimW+1)'(MAX_DIM)) return (DimW+1)'(MAX_DIM);
    return {1'b0, v};
  endfunction

  // Memories.
  logic [CountW-1:0] cnt_mem [MAX_DIM];
  logic [CountW-1:0] cur_mem [MAX_DIM];
  logic [DimW-1:0] ld_row_mem [MAX_NNZ];
  logic [DimW-1:0] ld_col_mem [MAX_NNZ];
  logic [ValW-1:0] ld_val_mem [MAX_NNZ];
  logic [DimW-1:0] st_row_mem [MAX_NNZ];
  logic [ValW-1:0] st_val_mem [MAX_NNZ];

  state_t state, state_next;
  item_t item;
  result_t res, res_next;
  logic out_valid;
  phase_t phase;
  logic [CountW-1:0] total;
  logic err;
  logic booting;
  logic [CW:0] idx;
  logic [NW:0] eidx;
  logic [CountW-1:0] sum;
  logic [DimW:0] emit_row, col_limit;
  logic [CountW-1:0] emit_pos, row_left;
  logic [CountW-1:0] cnt_q, cur_q;
  logic [DimW-1:0] ldr_q, ldc_q, str_q;
  logic [ValW-1:0] ldv_q, stv_q;
  logic bad;

  assign in_ch.ready = (state == ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = res;

  wire [CW-1:0] col_addr = CW'(item.col_index - DimW'(1));
  wire [CW-1:0] row_addr = CW'(emit_row - (DimW+1)'(1));
  wire [CW-1:0] mv_addr = CW'(ldc_q - DimW'(1));

  always_comb begin
    bad = (item.col_index == '0) || ({1'b0, item.col_index} > eff(num_cols)) ||
          (item.row_index == '0) || ({1'b0, item.row_index} > eff(num_rows)) ||
          (total >= CountW'(MAX_NNZ));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          if (in_ch.payload.opcode == OP_LOAD) begin
            state_next = (phase != PHASE_LOAD) ? ST_CLEAR : ST_LOAD;
          end else if (phase == PHASE_LOAD) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FETCH_RD;
          end
        end
      end
      ST_CLEAR: if (idx == (CW+1)'(MAX_DIM - 1)) state_next = booting ? ST_IDLE : ST_LOAD;
      ST_LOAD: state_next = ST_IDLE;
      ST_SCAN: state_next = ST_SCAN_ADD;
      ST_SCAN_ADD: begin
        if (idx == (CW+1)'(MAX_DIM - 1)) begin
          state_next = (total == '0) ? ST_FETCH_RD : ST_MOVE_RD;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_MOVE_RD: state_next = ST_MOVE_CUR;
      ST_MOVE_CUR: state_next = ST_MOVE_WR;
      ST_MOVE_WR: begin
        if ((NW+1)'(eidx + 1'b1) >= (NW+1)'(total)) state_next = ST_FETCH_RD;
        else state_next = ST_MOVE_RD;
      end
      ST_FETCH_RD: state_next = ST_FETCH_EMIT;
      ST_FETCH_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res_next = '0;
    res_next.load_error = err;
    if (phase == PHASE_DONE) begin
      res_next.kind = KIND_NONE;
    end else begin
      res_next.out_row = DimW'(emit_row);
      res_next.row_count = cnt_q;
      if (phase == PHASE_HEADER) begin
        res_next.kind = KIND_HEADER;
        res_next.last_in_row = (cnt_q == '0);
        res_next.last_of_all = (cnt_q == '0) && (emit_row >= col_limit);
      end else begin
        res_next.kind = KIND_ENTRY;
        res_next.out_col = str_q;
        res_next.out_value = stv_q;
        res_next.last_in_row = (row_left == CountW'(1));
        res_next.last_of_all = (row_left == CountW'(1)) && (emit_row >= col_limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) cnt_mem[idx[CW-1:0]] <= '0;
    else if (state == ST_LOAD && !bad) cnt_mem[col_addr] <= cnt_q + 1'b1;
    if (state == ST_SCAN_ADD) cur_mem[idx[CW-1:0]] <= sum;
    else if (state == ST_MOVE_WR) cur_mem[mv_addr] <= cur_q + 1'b1;
    if (state == ST_LOAD && !bad) begin
      ld_row_mem[total[NW-1:0]] <= item.row_index;
      ld_col_mem[total[NW-1:0]] <= item.col_index;
      ld_val_mem[total[NW-1:0]] <= item.entry_value;
    end
    if (state == ST_MOVE_WR) begin
      st_row_mem[cur_q[NW-1:0]] <= ldr_q;
      st_val_mem[cur_q[NW-1:0]] <= ldv_q;
    end
    case (state)
      ST_IDLE: cnt_q <= cnt_mem[CW'(in_ch.payload.col_index - DimW'(1))];
      ST_CLEAR: cnt_q <= '0;
      ST_SCAN: cnt_q <= cnt_mem[idx[CW-1:0]];
      ST_FETCH_RD: cnt_q <= cnt_mem[row_addr];
      default: cnt_q <= cnt_q;
    endcase
    cur_q <= cur_mem[mv_addr];
    ldr_q <= ld_row_mem[eidx[NW-1:0]];
    ldc_q <= ld_col_mem[eidx[NW-1:0]];
    ldv_q <= ld_val_mem[eidx[NW-1:0]];
    str_q <= st_row_mem[emit_pos[NW-1:0]];
    stv_q <= st_val_mem[emit_pos[NW-1:0]];
    if (in_ch.valid && in_ch.ready) item <= in_ch.payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      out_valid <= 1'b0;
      phase <= PHASE_LOAD;
      total <= '0;
      err <= 1'b0;
      booting <= 1'b1;
      idx <= '0;
      eidx <= '0;
      sum <= '0;
      emit_row <= '0;
      col_limit <= (DimW+1)'(1);
      emit_pos <= '0;
      row_left <= '0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          idx <= '0;
          eidx <= '0;
          sum <= '0;
          if (in_ch.valid && in_ch.ready && in_ch.payload.opcode == OP_LOAD &&
              phase != PHASE_LOAD) begin
            phase <= PHASE_LOAD;
            total <= '0;
          end
        end
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == (CW+1)'(MAX_DIM - 1)) booting <= 1'b0;
        end
        ST_LOAD: begin
          if (bad) err <= 1'b1;
          else total <= total + 1'b1;
        end
        ST_SCAN_ADD: begin
          sum <= sum + cnt_q;
          idx <= idx + 1'b1;
          if (idx == (CW+1)'(MAX_DIM - 1)) begin
            col_limit <= eff(num_cols);
            emit_row <= (DimW+1)'(1);
            emit_pos <= '0;
            row_left <= '0;
            phase <= PHASE_HEADER;
          end
        end
        ST_MOVE_WR: eidx <= eidx + 1'b1;
        ST_FETCH_EMIT: begin
          out_valid <= 1'b1;
          res <= res_next;
          if (phase == PHASE_HEADER) begin
            if (cnt_q == '0) begin
              if (emit_row >= col_limit) phase <= PHASE_DONE;
              else emit_row <= emit_row + 1'b1;
            end else begin
              row_left <= cnt_q;
              phase <= PHASE_ENTRY;
            end
          end else if (phase == PHASE_ENTRY) begin
            emit_pos <= emit_pos + 1'b1;
            row_left <= row_left - 1'b1;
            if (row_left == CountW'(1)) begin
              if (emit_row >= col_limit) phase <= PHASE_DONE;
              else begin
                emit_row <= emit_row + 1'b1;
                phase <= PHASE_HEADER;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic unused;
  assign unused = (|pwdata[31:DimW]) ^ (|paddr[1:0]);
endmodule
`default_nettype wire

[sv/smt_checker.sv]
`default_nettype none
module smt_checker
  import smt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_kind,
  input wire logic out_err
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accepted while result pending");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind != 2'd3) else $error("bad kind");
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_err |=> ##1 !out_valid || out_err)
    else $error("error flag cleared");
  logic unused;
  assign unused = in_valid;
endmodule

bind sparse_matrix_transpose_top smt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.payload.kind), .out_err(out_ch.payload.load_error)
);
`default_nettype wire
